// ===== rtl/prtt_pkg.sv =====
// shared types, constants and codes for the pending request timeout table
`timescale 1ns / 1ps

package prtt_pkg;

    // table geometry
    localparam int ENTRIES = 128;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int SLOT_W  = 7;
    localparam int TIER_W  = 8;

    // timeout register reset value
    localparam logic [TIER_W-1:0] TIMEOUT_RESET = 8'd5;

    // item opcodes
    localparam logic OP_CHECK = 1'b0;
    localparam logic OP_ADD   = 1'b1;

    // result status codes
    typedef logic [1:0] status_t;
    localparam status_t ST_NOT_PENDING = 2'd0;
    localparam status_t ST_PENDING     = 2'd1;
    localparam status_t ST_ADDED       = 2'd2;
    localparam status_t ST_FULL        = 2'd3;

    // one table row
    typedef struct packed {
        logic [31:0] send_time;
        logic [31:0] address;
        logic [15:0] port;
        logic [63:0] request;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // per-row values registered ahead of the evaluator
    typedef struct packed {
        logic [31:0] expiry;
        logic        addr_match;
        logic        id_match;
    } scan_t;

    // per-transaction values the evaluator needs
    typedef struct packed {
        logic [31:0]       now;
        logic [TIER_W-1:0] timeout;
        logic              addr_zero;
        logic              id_zero;
    } req_ctl_t;

    // evaluator verdict for one row
    typedef struct packed {
        logic              hit;
        logic              cand;
        logic [TIER_W-1:0] tier;
    } eval_t;

endpackage

// ===== rtl/prtt_ram.sv =====
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps

module prtt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                             aclk,
    input  logic                                             we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]     waddr,
    input  logic [WIDTH-1:0]                                 wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]     raddr,
    output logic [WIDTH-1:0]                                 rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/prtt_eval.sv =====
// per-row liveness, match and add tier evaluation
`timescale 1ns / 1ps

module prtt_eval (
    input  prtt_pkg::scan_t    row,
    input  prtt_pkg::req_ctl_t ctl,
    output prtt_pkg::eval_t    verdict
);

    import prtt_pkg::*;

    logic        live;
    logic        before_now;
    logic [31:0] diff;
    logic [31:0] tier_limit;

    // check: row is live and every requested key matches
    assign live = row.expiry > ctl.now;

    // add: the first tier t with (expiry - t) below now is expiry - now + 1
    assign before_now = row.expiry < ctl.now;
    assign diff       = row.expiry - ctl.now;
    assign tier_limit = {{(32 - TIER_W){1'b0}}, ctl.timeout} - 32'd1;

    always_comb begin
        verdict.hit  = live && (ctl.addr_zero || row.addr_match)
                            && (ctl.id_zero || row.id_match);
        verdict.cand = 1'b0;
        verdict.tier = '0;
        if ((ctl.now != 32'd0) && (ctl.timeout != '0)) begin
            if (before_now) begin
                verdict.cand = 1'b1;
            end else begin
                verdict.cand = diff < tier_limit;
                verdict.tier = diff[TIER_W-1:0] + TIER_W'(1);
            end
        end
    end

endmodule

// ===== rtl/pending_request_timeout_table.sv =====
// top level: outstanding request table with timeout, scanned one row per cycle
`timescale 1ns / 1ps

// Each transaction (check or add) scans every row of the table once through a
// single read port, one row per cycle, so a transaction occupies the block from
// acceptance to the result, its pace set by the read port of the row memory.
// s_ready is low during the scan.
// A check returns the lowest live row matching the given keys. An add picks the
// row with the lowest free tier during the same scan and writes it in the final
// cycle. Rows never written read as zero through per-row valid bits cleared by
// reset, so no clearing pass is needed. The timeout register is written through
// cfg_we/cfg_wdata and should only be changed while the block is idle.

module pending_request_timeout_table (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration
    input  logic                  cfg_we,
    input  logic [7:0]            cfg_wdata,
    // request channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_opcode,
    input  logic [31:0]           s_now_seconds,
    input  logic [31:0]           s_peer_address,
    input  logic [15:0]           s_peer_port,
    input  logic [63:0]           s_request_id,
    // result channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output prtt_pkg::status_t     m_status,
    output logic [6:0]            m_slot
);

    import prtt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_FIN  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [TIER_W-1:0] timeout_reg;

    // captured transaction
    logic        op_reg;
    logic [31:0] now_reg;
    logic [31:0] addr_reg;
    logic [15:0] port_reg;
    logic [63:0] id_reg;

    // scan pipeline
    logic [CNT_W-1:0]   rd_cnt_reg;
    logic               a_vld_reg;
    logic [IDX_W-1:0]   a_idx_reg;
    logic               a_vbit_reg;
    logic               b_vld_reg;
    logic [IDX_W-1:0]   b_idx_reg;
    scan_t              b_row_reg;

    // running best
    logic               found_reg;
    logic [IDX_W-1:0]   best_idx_reg;
    logic [TIER_W-1:0]  best_tier_reg;

    // row valid bits
    logic [ENTRIES-1:0] vbit_reg;

    // output register
    logic               m_valid_reg;
    status_t            m_status_reg;
    logic [SLOT_W-1:0]  m_slot_reg;

    logic               accept;
    logic               issue;
    logic               scan_done;
    logic               fin_go;
    logic               wr_en;
    logic [IDX_W-1:0]   rd_addr;
    logic [ENTRY_W-1:0] rd_data;
    entry_t             a_entry;
    entry_t             wr_entry;
    scan_t              a_row;
    req_ctl_t           ctl;
    eval_t              verdict;

    assign s_ready   = (state_reg == S_IDLE);
    assign accept    = s_valid && s_ready;
    assign issue     = (state_reg == S_SCAN) && (rd_cnt_reg != CNT_W'(ENTRIES));
    assign scan_done = (state_reg == S_SCAN) && (rd_cnt_reg == CNT_W'(ENTRIES))
                       && !a_vld_reg && !b_vld_reg;
    assign fin_go    = (state_reg == S_FIN) && (!m_valid_reg || m_ready);
    assign wr_en     = fin_go && (op_reg == OP_ADD) && found_reg;
    assign rd_addr   = rd_cnt_reg[IDX_W-1:0];

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_done) begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (fin_go) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // timeout register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= TIMEOUT_RESET;
        end else if (cfg_we) begin
            timeout_reg <= cfg_wdata;
        end
    end

    // capture the transaction
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg   <= s_opcode;
            now_reg  <= s_now_seconds;
            addr_reg <= s_peer_address;
            port_reg <= s_peer_port;
            id_reg   <= s_request_id;
        end
    end

    // row memory
    assign wr_entry.send_time = now_reg;
    assign wr_entry.address   = addr_reg;
    assign wr_entry.port      = port_reg;
    assign wr_entry.request   = id_reg;

    prtt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_rows (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (best_idx_reg),
        .wdata (wr_entry),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // valid bits, unwritten rows read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vbit_reg <= '0;
        end else if (wr_en) begin
            vbit_reg[best_idx_reg] <= 1'b1;
        end
    end

    // read issue counter and stage a control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_cnt_reg <= '0;
            a_vld_reg  <= 1'b0;
            b_vld_reg  <= 1'b0;
        end else begin
            if (accept) begin
                rd_cnt_reg <= '0;
            end else if (issue) begin
                rd_cnt_reg <= rd_cnt_reg + CNT_W'(1);
            end
            a_vld_reg <= issue;
            b_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        a_idx_reg  <= rd_addr;
        a_vbit_reg <= vbit_reg[rd_addr];
    end

    // stage a: expiry and key compares
    assign a_entry          = a_vbit_reg ? entry_t'(rd_data) : '0;
    assign a_row.expiry     = a_entry.send_time + {24'd0, timeout_reg};
    assign a_row.addr_match = (a_entry.address == addr_reg) && (a_entry.port == port_reg);
    assign a_row.id_match   = a_entry.request == id_reg;

    always_ff @(posedge aclk) begin
        b_idx_reg <= a_idx_reg;
        b_row_reg <= a_row;
    end

    // stage b: shared evaluator
    assign ctl.now       = now_reg;
    assign ctl.timeout   = timeout_reg;
    assign ctl.addr_zero = addr_reg == 32'd0;
    assign ctl.id_zero   = id_reg == 64'd0;

    prtt_eval u_eval (
        .row     (b_row_reg),
        .ctl     (ctl),
        .verdict (verdict)
    );

    // running best: first hit for check, lowest tier then lowest row for add
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else if (accept) begin
            found_reg <= 1'b0;
        end else if (b_vld_reg) begin
            if (op_reg == OP_CHECK) begin
                if (verdict.hit && !found_reg) begin
                    found_reg <= 1'b1;
                end
            end else if (verdict.cand && (!found_reg || (verdict.tier < best_tier_reg))) begin
                found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (b_vld_reg) begin
            if (op_reg == OP_CHECK) begin
                if (verdict.hit && !found_reg) begin
                    best_idx_reg <= b_idx_reg;
                end
            end else if (verdict.cand && (!found_reg || (verdict.tier < best_tier_reg))) begin
                best_idx_reg  <= b_idx_reg;
                best_tier_reg <= verdict.tier;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fin_go) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fin_go) begin
            if (op_reg == OP_CHECK) begin
                m_status_reg <= found_reg ? ST_PENDING : ST_NOT_PENDING;
            end else begin
                m_status_reg <= found_reg ? ST_ADDED : ST_FULL;
            end
            m_slot_reg <= found_reg ? SLOT_W'(best_idx_reg) : '0;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_slot   = m_slot_reg;

    // a result only appears out of the final state
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_FIN))
        else $error("result raised outside the final state");

    // the table is written only for an add that found a row
    assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (state_reg == S_FIN) && (op_reg == OP_ADD) && found_reg)
        else $error("row written outside a successful add");

    // scan pipeline is empty whenever a new transaction can be taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> (!a_vld_reg && !b_vld_reg))
        else $error("scan pipeline busy while idle");

    // misses and full tables report slot zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && ((m_status_reg == ST_NOT_PENDING) || (m_status_reg == ST_FULL)))
        |-> (m_slot_reg == '0))
        else $error("non-zero slot on a miss or full result");

endmodule
